>>> design/wtl_pkg.sv
`timescale 1ns / 1ps

package wtl_pkg;

   localparam int MaxWindows = 64;
   localparam int MinWidth   = 160;
   localparam int MinHeight  = 120;
   localparam int InsetDiv   = 12;
   // reciprocal scaling for the 16-bit quotient path and the index split
   localparam int RecipShift = 24;
   localparam int IdxShift   = 12;

   typedef enum logic [1:0] {
      PRESET_FOCUS   = 2'd0,
      PRESET_COLUMNS = 2'd1,
      PRESET_GRID    = 2'd2
   } preset_type;

   typedef enum logic [1:0] {
      ACT_POSITION = 2'd0,
      ACT_MINIMIZE = 2'd1,
      ACT_RANGE    = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      CSR_AREA_LEFT   = 2'd0,
      CSR_AREA_TOP    = 2'd1,
      CSR_AREA_RIGHT  = 2'd2,
      CSR_AREA_BOTTOM = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [6:0] window_total;
      logic [5:0] window_index;
   } req_type_type;

   typedef struct packed {
      logic signed [15:0] rect_left;
      logic signed [15:0] rect_top;
      logic signed [15:0] rect_right;
      logic signed [15:0] rect_bottom;
      logic        [1:0]  action;
   } rsp_type;

endpackage

>>> design/wtl_scale.sv
`timescale 1ns / 1ps

// Registered quotient: floor(num / d) as (num * ceil(2^24 / d)) >> 24.
module wtl_scale (
   input  logic        clock,
   input  logic [15:0] num,
   input  logic [24:0] recip,
   output logic [15:0] quot
);
   import wtl_pkg::*;

   logic [40:0] prod;
   logic [15:0] quot_ff;

   assign prod = {25'd0, num} * {16'd0, recip};

   always_ff @(posedge clock) begin
      quot_ff <= prod[RecipShift +: 16];
   end

   assign quot = quot_ff;

endmodule

>>> design/window_tiling_layout_top.sv
`timescale 1ns / 1ps

// Window tiling layout. A transaction (preset, window count, window index) is taken at any
// clock edge with start high and busy low; busy is high only while reset is held, so one
// transaction per cycle is sustained once reset is released.
// The placed rectangle appears on rsp_item with rsp_valid high for exactly one cycle; the
// receiver cannot stall and every result must be taken then. The datapath is a six-stage
// pipeline: decode and reciprocal lookup, quotient multiply, column/row split, offset
// multiply, edge adds, minimum size and saturation.
// The work area registers are written through csr_we/csr_index/csr_wdata and must only be
// changed while no transaction is in flight.
module window_tiling_layout_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  wtl_pkg::req_type_type req_item,
   output logic                  rsp_valid,
   output wtl_pkg::rsp_type      rsp_item,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata
);
   import wtl_pkg::*;

   // ---------------- work area registers ----------------
   logic signed [15:0] area_left_ff, area_top_ff, area_right_ff, area_bottom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         area_left_ff   <= 16'sd0;
         area_top_ff    <= 16'sd0;
         area_right_ff  <= 16'sd1920;
         area_bottom_ff <= 16'sd1080;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_AREA_LEFT:   area_left_ff   <= csr_wdata;
            CSR_AREA_TOP:    area_top_ff    <= csr_wdata;
            CSR_AREA_RIGHT:  area_right_ff  <= csr_wdata;
            CSR_AREA_BOTTOM: area_bottom_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- constant tables ----------------
   // recip_tab[d] = ceil(2^24/d): exact floor for 16-bit numerators, d up to 64
   // idx_tab[c]   = ceil(2^12/c): exact floor for 6-bit indices, c up to 8
   // grid_cols/grid_rows by clamped count
   logic [24:0] recip_tab [0:MaxWindows];
   logic [12:0] idx_tab   [0:8];
   logic [3:0]  grid_cols [0:MaxWindows];
   logic [6:0]  grid_rows [0:MaxWindows];

   function automatic int ceil_sqrt(input int n);
      int c;
      c = 1;
      while (c * c < n) c++;
      return c;
   endfunction

   assign recip_tab[0] = '0;
   assign idx_tab[0]   = '0;
   assign grid_cols[0] = 4'd1;
   assign grid_rows[0] = 7'd1;

   for (genvar d = 1; d <= MaxWindows; d++) begin : g_recip
      localparam int Recip = ((1 << RecipShift) + d - 1) / d;
      localparam int Cols  = (d <= 2) ? d : ceil_sqrt(d);
      localparam int Rows  = (d + Cols - 1) / Cols;
      assign recip_tab[d] = 25'(Recip);
      assign grid_cols[d] = 4'(Cols);
      assign grid_rows[d] = 7'(Rows);
   end

   for (genvar c = 1; c <= 8; c++) begin : g_idx
      localparam int Recip = ((1 << IdxShift) + c - 1) / c;
      assign idx_tab[c] = 13'(Recip);
   end

   // ---------------- stage 1: decode ----------------
   logic               accept;
   logic [6:0]         cnt;
   logic signed [16:0] wdiff, hdiff;
   preset_type         preset;
   logic [6:0]         div_x_in, div_y_in;

   logic               s1_valid_ff;
   preset_type         s1_preset_ff;
   action_type         s1_action_ff;
   logic [5:0]         s1_idx_ff;
   logic [6:0]         s1_cnt_ff;
   logic [15:0]        s1_width_ff, s1_height_ff;
   logic [24:0]        s1_rx_ff, s1_ry_ff;
   logic [3:0]         s1_cols_ff;
   logic [6:0]         s1_rows_ff;
   logic [12:0]        s1_rc_ff;

   assign busy   = reset;
   assign accept = start && !busy;
   assign cnt    = (req_item.window_total > 7'(MaxWindows)) ? 7'(MaxWindows)
                                                            : req_item.window_total;
   assign wdiff  = {area_right_ff[15], area_right_ff} - {area_left_ff[15], area_left_ff};
   assign hdiff  = {area_bottom_ff[15], area_bottom_ff} - {area_top_ff[15], area_top_ff};

   always_comb begin
      unique case (req_item.req_type)
         PRESET_FOCUS:   preset = PRESET_FOCUS;
         PRESET_COLUMNS: preset = PRESET_COLUMNS;
         default:        preset = PRESET_GRID;   // code 3 acts as grid
      endcase
      unique case (preset)
         PRESET_FOCUS: begin
            div_x_in = 7'(InsetDiv);
            div_y_in = 7'(InsetDiv);
         end
         PRESET_COLUMNS: begin
            div_x_in = cnt;
            div_y_in = 7'd1;
         end
         default: begin
            div_x_in = {3'd0, grid_cols[cnt]};
            div_y_in = grid_rows[cnt];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= accept;
   end

   always_ff @(posedge clock) begin
      s1_preset_ff <= preset;
      if ({1'b0, req_item.window_index} >= cnt)
         s1_action_ff <= ACT_RANGE;
      else if (preset == PRESET_FOCUS && req_item.window_index != 6'd0)
         s1_action_ff <= ACT_MINIMIZE;
      else
         s1_action_ff <= ACT_POSITION;
      s1_idx_ff    <= req_item.window_index;
      s1_cnt_ff    <= cnt;
      s1_width_ff  <= (wdiff < 17'sd1) ? 16'd1 : wdiff[15:0];
      s1_height_ff <= (hdiff < 17'sd1) ? 16'd1 : hdiff[15:0];
      s1_rx_ff     <= recip_tab[div_x_in];
      s1_ry_ff     <= recip_tab[div_y_in];
      s1_cols_ff   <= grid_cols[cnt];
      s1_rows_ff   <= grid_rows[cnt];
      s1_rc_ff     <= idx_tab[grid_cols[cnt]];
   end

   // ---------------- stage 2: quotients, grid row ----------------
   logic [15:0] qx, qy;
   logic [18:0] row_prod;

   wtl_scale u_scale_x (.clock(clock), .num(s1_width_ff),  .recip(s1_rx_ff), .quot(qx));
   wtl_scale u_scale_y (.clock(clock), .num(s1_height_ff), .recip(s1_ry_ff), .quot(qy));

   assign row_prod = {13'd0, s1_idx_ff} * {6'd0, s1_rc_ff};

   logic       s2_valid_ff;
   preset_type s2_preset_ff;
   action_type s2_action_ff;
   logic [5:0] s2_idx_ff, s2_row_ff;
   logic [6:0] s2_cnt_ff, s2_rows_ff;
   logic [3:0] s2_cols_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      s2_preset_ff <= s1_preset_ff;
      s2_action_ff <= s1_action_ff;
      s2_idx_ff    <= s1_idx_ff;
      s2_row_ff    <= row_prod[IdxShift +: 6];
      s2_cnt_ff    <= s1_cnt_ff;
      s2_rows_ff   <= s1_rows_ff;
      s2_cols_ff   <= s1_cols_ff;
   end

   // ---------------- stage 3: column, multipliers, last flags ----------------
   logic [9:0] row_cols;
   logic [5:0] col;
   logic [5:0] xi_in, yi_in;
   logic       lastx_in, lasty_in;

   assign row_cols = {4'd0, s2_row_ff} * {6'd0, s2_cols_ff};
   assign col      = s2_idx_ff - row_cols[5:0];

   always_comb begin
      unique case (s2_preset_ff)
         PRESET_FOCUS: begin
            xi_in    = 6'd1;
            yi_in    = 6'd1;
            lastx_in = 1'b0;
            lasty_in = 1'b0;
         end
         PRESET_COLUMNS: begin
            xi_in    = s2_idx_ff;
            yi_in    = 6'd0;
            lastx_in = ({1'b0, s2_idx_ff} + 7'd1) == s2_cnt_ff;
            lasty_in = 1'b1;
         end
         default: begin
            xi_in    = col;
            yi_in    = s2_row_ff;
            lastx_in = ({1'b0, col} + 7'd1) == {3'd0, s2_cols_ff};
            lasty_in = ({1'b0, s2_row_ff} + 7'd1) == s2_rows_ff;
         end
      endcase
   end

   logic        s3_valid_ff;
   preset_type  s3_preset_ff;
   action_type  s3_action_ff;
   logic [5:0]  s3_xi_ff, s3_yi_ff;
   logic        s3_lastx_ff, s3_lasty_ff;
   logic [15:0] s3_qx_ff, s3_qy_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else       s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      s3_preset_ff <= s2_preset_ff;
      s3_action_ff <= s2_action_ff;
      s3_xi_ff     <= xi_in;
      s3_yi_ff     <= yi_in;
      s3_lastx_ff  <= lastx_in;
      s3_lasty_ff  <= lasty_in;
      s3_qx_ff     <= qx;
      s3_qy_ff     <= qy;
   end

   // ---------------- stage 4: offsets ----------------
   logic [21:0] offx_in, offy_in;

   assign offx_in = {16'd0, s3_xi_ff} * {6'd0, s3_qx_ff};
   assign offy_in = {16'd0, s3_yi_ff} * {6'd0, s3_qy_ff};

   logic        s4_valid_ff;
   preset_type  s4_preset_ff;
   action_type  s4_action_ff;
   logic        s4_lastx_ff, s4_lasty_ff;
   logic [15:0] s4_qx_ff, s4_qy_ff;
   logic [21:0] s4_offx_ff, s4_offy_ff;

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else       s4_valid_ff <= s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      s4_preset_ff <= s3_preset_ff;
      s4_action_ff <= s3_action_ff;
      s4_lastx_ff  <= s3_lastx_ff;
      s4_lasty_ff  <= s3_lasty_ff;
      s4_qx_ff     <= s3_qx_ff;
      s4_qy_ff     <= s3_qy_ff;
      s4_offx_ff   <= offx_in;
      s4_offy_ff   <= offy_in;
   end

   // ---------------- stage 5: raw edges ----------------
   logic signed [24:0] l_in, t_in, r_in, b_in;
   logic signed [24:0] wl25, wt25, wr25, wb25, qx25, qy25;

   assign wl25 = 25'(area_left_ff);
   assign wt25 = 25'(area_top_ff);
   assign wr25 = 25'(area_right_ff);
   assign wb25 = 25'(area_bottom_ff);
   assign qx25 = $signed({9'd0, s4_qx_ff});
   assign qy25 = $signed({9'd0, s4_qy_ff});
   assign l_in = wl25 + $signed({3'd0, s4_offx_ff});
   assign t_in = wt25 + $signed({3'd0, s4_offy_ff});

   always_comb begin
      if (s4_preset_ff == PRESET_FOCUS) begin
         r_in = wr25 - qx25;
         b_in = wb25 - qy25;
      end else begin
         r_in = s4_lastx_ff ? wr25 : l_in + qx25;
         b_in = s4_lasty_ff ? wb25 : t_in + qy25;
      end
   end

   logic               s5_valid_ff;
   action_type         s5_action_ff;
   logic signed [24:0] s5_l_ff, s5_t_ff, s5_r_ff, s5_b_ff;

   always_ff @(posedge clock) begin
      if (reset) s5_valid_ff <= 1'b0;
      else       s5_valid_ff <= s4_valid_ff;
   end

   always_ff @(posedge clock) begin
      s5_action_ff <= s4_action_ff;
      s5_l_ff      <= l_in;
      s5_t_ff      <= t_in;
      s5_r_ff      <= r_in;
      s5_b_ff      <= b_in;
   end

   // ---------------- stage 6: minimum size, saturation ----------------
   function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
      if (v > 25'sd32767)       return 16'sh7fff;
      else if (v < -25'sd32768) return 16'sh8000;
      else                      return v[15:0];
   endfunction

   logic signed [24:0] r_fix, b_fix;
   rsp_type            rsp_in;

   assign r_fix = (s5_r_ff - s5_l_ff < 25'(MinWidth))  ? s5_l_ff + 25'(MinWidth)  : s5_r_ff;
   assign b_fix = (s5_b_ff - s5_t_ff < 25'(MinHeight)) ? s5_t_ff + 25'(MinHeight) : s5_b_ff;

   always_comb begin
      rsp_in.action = s5_action_ff;
      if (s5_action_ff == ACT_POSITION) begin
         rsp_in.rect_left   = sat16(s5_l_ff);
         rsp_in.rect_top    = sat16(s5_t_ff);
         rsp_in.rect_right  = sat16(r_fix);
         rsp_in.rect_bottom = sat16(b_fix);
      end else begin
         rsp_in.rect_left   = '0;
         rsp_in.rect_top    = '0;
         rsp_in.rect_right  = '0;
         rsp_in.rect_bottom = '0;
      end
   end

   logic    s6_valid_ff;
   rsp_type s6_rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) s6_valid_ff <= 1'b0;
      else       s6_valid_ff <= s5_valid_ff;
   end

   always_ff @(posedge clock) begin
      s6_rsp_ff <= rsp_in;
   end

   assign rsp_valid = s6_valid_ff;
   assign rsp_item  = s6_rsp_ff;

   // ---------------- assertions ----------------
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##6 rsp_valid)
      else $error("result missing six cycles after accept");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 6))
      else $error("result without a matching transaction");

   a_zero_rect: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.action != ACT_POSITION) |->
         (rsp_item.rect_left == 16'sd0 && rsp_item.rect_right == 16'sd0 &&
          rsp_item.rect_top == 16'sd0 && rsp_item.rect_bottom == 16'sd0))
      else $error("non-placed result carries a rectangle");

   a_minimize_focus: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_action_ff == ACT_MINIMIZE) |-> s2_preset_ff == PRESET_FOCUS)
      else $error("minimize outside focus preset");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

// Testbench for window_tiling_layout_top.
// Requests are queued by the stimulus process, driven at the rising edge by the driver
// and predicted as they are accepted; the monitor checks every strobed result against
// the oldest predicted rectangle. The work area is rewritten between phases, only once
// every outstanding transaction has returned and the pipeline has drained.
module tb_top;
   import wtl_pkg::*;

   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 12;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   req_type_type  req_item = '0;
   logic          rsp_valid;
   rsp_type       rsp_item;
   logic          csr_we = 1'b0;
   logic [1:0]    csr_index = '0;
   logic [15:0]   csr_wdata = '0;

   // work area as the predictor sees it
   logic signed [15:0] area_l, area_t, area_r, area_b;

   req_type_type pending_reqs[$];
   rsp_type      expected_rects[$];
   int           errors = 0;
   int           idle_cycles = 0;
   bit           calm = 1'b0;   // no idling on the driver while set

   window_tiling_layout_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic logic [15:0] sat16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   // placement of one window in the current work area
   function automatic rsp_type place_window(req_type_type rq);
      rsp_type res;
      longint width, height, cnt, idx, l, t, r, b, cw, ch, cols, rows, col, row;
      res = '0;
      width  = longint'(area_r) - longint'(area_l);
      height = longint'(area_b) - longint'(area_t);
      if (width < 1) width = 1;
      if (height < 1) height = 1;
      cnt = rq.window_total;
      if (cnt > MaxWindows) cnt = MaxWindows;
      idx = rq.window_index;
      if (idx >= cnt) begin
         res.action = ACT_RANGE;
         return res;
      end
      if (rq.req_type == PRESET_FOCUS) begin
         if (idx != 0) begin
            res.action = ACT_MINIMIZE;
            return res;
         end
         l = area_l + width / InsetDiv;
         r = area_r - width / InsetDiv;
         t = area_t + height / InsetDiv;
         b = area_b - height / InsetDiv;
      end else if (rq.req_type == PRESET_COLUMNS) begin
         cw = width / cnt;
         l = area_l + idx * cw;
         r = (idx + 1 == cnt) ? longint'(area_r) : l + cw;
         t = area_t;
         b = area_b;
      end else begin
         // grid; code 3 falls here too
         if (cnt <= 2) cols = cnt;
         else begin
            cols = 1;
            while (cols * cols < cnt) cols++;
         end
         rows = (cnt + cols - 1) / cols;
         cw = width / cols;
         ch = height / rows;
         col = idx % cols;
         row = idx / cols;
         l = area_l + col * cw;
         t = area_t + row * ch;
         r = (col + 1 == cols) ? longint'(area_r) : l + cw;
         b = (row + 1 == rows) ? longint'(area_b) : t + ch;
      end
      if (r - l < MinWidth) r = l + MinWidth;
      if (b - t < MinHeight) b = t + MinHeight;
      res.rect_left   = sat16(l);
      res.rect_top    = sat16(t);
      res.rect_right  = sat16(r);
      res.rect_bottom = sat16(b);
      res.action      = ACT_POSITION;
      return res;
   endfunction

   // driver: one transaction per accepting edge, random gaps unless calm
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rects = {expected_rects, place_window(req_item)};
            void'(pending_reqs.pop_front());
         end
         // decide the next cycle's drive from the queue as it now stands
         if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 15)) begin
            start    <= 1'b1;
            req_item <= pending_reqs[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rects.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
         end else begin
            rsp_type e;
            e = expected_rects.pop_front();
            if (rsp_item.rect_left !== e.rect_left) begin
               $error("rect_left exp %0d got %0d", e.rect_left, rsp_item.rect_left);
               errors++;
            end
            if (rsp_item.rect_top !== e.rect_top) begin
               $error("rect_top exp %0d got %0d", e.rect_top, rsp_item.rect_top);
               errors++;
            end
            if (rsp_item.rect_right !== e.rect_right) begin
               $error("rect_right exp %0d got %0d", e.rect_right, rsp_item.rect_right);
               errors++;
            end
            if (rsp_item.rect_bottom !== e.rect_bottom) begin
               $error("rect_bottom exp %0d got %0d", e.rect_bottom, rsp_item.rect_bottom);
               errors++;
            end
            if (rsp_item.action !== e.action) begin
               $error("action exp %0d got %0d", e.action, rsp_item.action);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles with nothing accepted on either side
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("[window_tiling_layout_top] ERROR");
         $finish;
      end
   end

   task automatic queue_req(logic [1:0] pt, int cnt, int idx);
      req_type_type rq;
      rq.req_type     = pt;
      rq.window_total = cnt[6:0];
      rq.window_index = idx[5:0];
      pending_reqs = {pending_reqs, rq};
   endtask

   // waits for queues to empty and the pipeline to drain
   task automatic drain();
      while (pending_reqs.size() > 0 || expected_rects.size() > 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // write enable stays high across back-to-back writes; set_area lowers it
   task automatic write_area(logic [1:0] idx, logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_AREA_LEFT:   area_l = val;
         CSR_AREA_TOP:    area_t = val;
         CSR_AREA_RIGHT:  area_r = val;
         default:         area_b = val;
      endcase
   endtask

   task automatic set_area(logic [15:0] l, logic [15:0] t, logic [15:0] r, logic [15:0] b);
      drain();
      write_area(CSR_AREA_LEFT, l);
      write_area(CSR_AREA_TOP, t);
      write_area(CSR_AREA_RIGHT, r);
      write_area(CSR_AREA_BOTTOM, b);
      csr_we <= 1'b0;
   endtask

   // mostly in-range requests, a share of random noise across the full fields
   task automatic random_batch(int n);
      int cnt;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) < 8) begin
            cnt = $urandom_range(4) == 0 ? $urandom_range(64, 1) : $urandom_range(12, 1);
            queue_req(2'($urandom_range(3)), cnt, $urandom_range(cnt - 1));
         end else begin
            queue_req(2'($urandom_range(3)), $urandom_range(127), $urandom_range(63));
         end
      end
   endtask

   initial begin
      area_l = 16'sd0; area_t = 16'sd0; area_r = 16'sd1920; area_b = 16'sd1080;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every preset, count extremes, out of range, code 3, zero count
      calm = 1'b1;
      queue_req(PRESET_FOCUS, 1, 0);
      queue_req(PRESET_FOCUS, 5, 3);
      queue_req(PRESET_FOCUS, 64, 63);
      queue_req(PRESET_COLUMNS, 3, 0);
      queue_req(PRESET_COLUMNS, 3, 2);
      queue_req(PRESET_COLUMNS, 64, 63);
      queue_req(PRESET_COLUMNS, 127, 63);
      queue_req(PRESET_GRID, 2, 1);
      queue_req(PRESET_GRID, 5, 4);
      queue_req(PRESET_GRID, 10, 9);
      queue_req(PRESET_GRID, 64, 0);
      queue_req(2'd3, 7, 6);
      queue_req(PRESET_GRID, 0, 0);
      queue_req(PRESET_COLUMNS, 4, 4);
      queue_req(PRESET_FOCUS, 100, 63);
      queue_req(2'd3, 85, 42);
      drain();
      calm = 1'b0;

      random_batch(100);
      // saturating area at the extremes
      set_area(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
      queue_req(PRESET_FOCUS, 1, 0);
      queue_req(PRESET_GRID, 64, 63);
      random_batch(80);
      // inverted area: width and height taken as 1
      set_area(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
      queue_req(PRESET_COLUMNS, 1, 0);
      random_batch(60);
      // small, narrow area and an empty one near the top edge
      set_area(16'd100, 16'd50, 16'd400, 16'd90);
      random_batch(60);
      set_area(16'h7ff0, 16'h7ff0, 16'h7ff0, 16'h7ff0);
      random_batch(50);
      // long stretch with no driver idling
      set_area(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      calm = 1'b1;
      random_batch(100);
      drain();
      calm = 1'b0;
      set_area(16'hfc00, 16'hfe00, 16'd2560, 16'd1440);
      random_batch(100);
      drain();

      if (errors == 0 && expected_rects.size() == 0)
         $display("[window_tiling_layout_top] OK");
      else
         $display("[window_tiling_layout_top] ERROR");
      $finish;
   end

endmodule

>>> filelist.f
design/wtl_pkg.sv
design/wtl_scale.sv
design/window_tiling_layout_top.sv
tb/tb_top.sv
